### rtl/btnck_pkg.sv
// Package for the beam top-N candidate keeper.
// Holds the store geometry and the command and status structs between
// controller and datapath. Depends on nothing.
`default_nettype none
package btnck_pkg;

  localparam int STORE_DEPTH = 8;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int SCORE_W     = 32;
  localparam int SRC_W       = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch the candidate of an accepted transaction
    idx_t rd_addr;  // store entry to read this cycle
    logic wr_en;    // write one store entry
    idx_t wr_addr;
    logic wr_new;   // 1 writes the candidate, 0 writes the entry read
    logic out_load; // present the entry read as a result
    logic out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ge;       // entry read scores at least the candidate
  } sts_t;

endpackage
`default_nettype wire

### rtl/btnck_ctrl.sv
// Controller of the beam top-N candidate keeper: state machine, fill count,
// shift index and emit index. Depends on btnck_pkg.
`default_nettype none
module btnck_ctrl #(
  parameter int Cap = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire              start_new,
  input  wire              emit_after,
  output logic             busy,
  output btnck_pkg::cmd_t  cmd,
  input  btnck_pkg::sts_t  sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam btnck_pkg::cnt_t CAP_CNT  = btnck_pkg::CNT_W'(Cap);
  localparam btnck_pkg::idx_t CAP_LAST = btnck_pkg::IDX_W'(Cap - 1);

  logic [1:0]      state, state_next;
  btnck_pkg::cnt_t count, count_next;
  btnck_pkg::idx_t pos, pos_next;
  btnck_pkg::idx_t rank, rank_next;
  logic            emit, emit_next;
  logic            rank_last;

  assign busy      = (state != S_IDLE);
  assign rank_last = (({1'b0, rank} + btnck_pkg::cnt_t'(1)) == count);

  always_comb begin
    state_next   = state;
    count_next   = count;
    pos_next     = pos;
    rank_next    = rank;
    emit_next    = emit;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          emit_next = emit_after;
          rank_next = '0;
          if (start_new) begin
            count_next = btnck_pkg::cnt_t'(1);
            pos_next   = '0;
            state_next = S_SHIFT;
          end else if (count == CAP_CNT) begin
            pos_next   = CAP_LAST;
            state_next = S_CHECK;
          end else begin
            count_next = count + btnck_pkg::cnt_t'(1);
            pos_next   = count[btnck_pkg::IDX_W-1:0];
            state_next = S_SHIFT;
          end
        end
      end
      S_CHECK: begin
        // A full list keeps its lowest entry unless the candidate beats it.
        cmd.rd_addr = CAP_LAST;
        if (sts.ge) begin
          state_next = emit ? S_EMIT : S_IDLE;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // Walk up from the free slot, moving lower-scoring entries down one.
        cmd.rd_addr = pos - btnck_pkg::idx_t'(1);
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = pos;
        if (pos == '0 || sts.ge) begin
          cmd.wr_new = 1'b1;
          state_next = emit ? S_EMIT : S_IDLE;
        end else begin
          pos_next = pos - btnck_pkg::idx_t'(1);
        end
      end
      S_EMIT: begin
        cmd.rd_addr  = rank;
        cmd.out_load = 1'b1;
        cmd.out_last = rank_last;
        if (rank_last) begin
          state_next = S_IDLE;
        end else begin
          rank_next = rank + btnck_pkg::idx_t'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pos   <= '0;
      rank  <= '0;
      emit  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pos   <= pos_next;
      rank  <= rank_next;
      emit  <= emit_next;
    end
  end

endmodule
`default_nettype wire

### rtl/btnck_datapath.sv
// Datapath of the beam top-N candidate keeper: candidate register, the
// eight-entry store, score compare and result registers. Depends on btnck_pkg.
`default_nettype none
module btnck_datapath (
  input  wire                              clk,
  input  wire                              rst,
  input  btnck_pkg::cmd_t                  cmd,
  output btnck_pkg::sts_t                  sts,
  input  wire [btnck_pkg::SCORE_W-1:0]     cand_score,
  input  wire                              cand_tag,
  input  wire [btnck_pkg::SRC_W-1:0]       cand_source,
  output logic                             out_strobe,
  output logic [btnck_pkg::SCORE_W-1:0]    out_score,
  output logic                             out_tag,
  output logic [btnck_pkg::SRC_W-1:0]      out_source,
  output logic [btnck_pkg::IDX_W-1:0]      out_rank,
  output logic                             run_last
);

  logic [btnck_pkg::SCORE_W-1:0] score_q;
  logic                          tag_q;
  logic [btnck_pkg::SRC_W-1:0]   src_q;

  logic [btnck_pkg::SCORE_W-1:0] kept_score [btnck_pkg::STORE_DEPTH];
  logic                          kept_tag   [btnck_pkg::STORE_DEPTH];
  logic [btnck_pkg::SRC_W-1:0]   kept_src   [btnck_pkg::STORE_DEPTH];

  logic [btnck_pkg::SCORE_W-1:0] rd_score;
  logic                          rd_tag;
  logic [btnck_pkg::SRC_W-1:0]   rd_src;

  assign rd_score = kept_score[cmd.rd_addr];
  assign rd_tag   = kept_tag[cmd.rd_addr];
  assign rd_src   = kept_src[cmd.rd_addr];
  assign sts.ge   = (rd_score >= score_q);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      score_q <= cand_score;
      tag_q   <= cand_tag;
      src_q   <= cand_source;
    end
    if (cmd.wr_en) begin
      kept_score[cmd.wr_addr] <= cmd.wr_new ? score_q : rd_score;
      kept_tag[cmd.wr_addr]   <= cmd.wr_new ? tag_q   : rd_tag;
      kept_src[cmd.wr_addr]   <= cmd.wr_new ? src_q   : rd_src;
    end
    if (cmd.out_load) begin
      out_score  <= rd_score;
      out_tag    <= rd_tag;
      out_source <= rd_src;
      out_rank   <= cmd.rd_addr;
      run_last   <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.out_load;
    end
  end

endmodule
`default_nettype wire

### rtl/beam_top_n_candidate_keeper_top.sv
// Top level of the beam top-N candidate keeper: controller and datapath.
// Depends on btnck_pkg, btnck_ctrl and btnck_datapath.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------------
//   input    | start, busy             | cand_score, cand_tag, cand_source,
//            |                         | start_new, emit_after
//   result   | out_strobe              | out_score, out_tag, out_source,
//            |                         | out_rank, run_last
//
// An insert moves each lower-scoring store entry down one place, one at a
// time as the single read port of the store allows, then writes the candidate;
// a full list first compares its lowest entry and drops a candidate that does
// not beat it. An emit then reads out every kept entry. Each result appears in
// the cycle after it is read and is held for one cycle only, since the receiver
// cannot stall. Reset clears the fill count and the controller, not the store.
`default_nettype none
module beam_top_n_candidate_keeper_top #(
  parameter int BEAM_WIDTH = 8
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire [btnck_pkg::SCORE_W-1:0]  cand_score,
  input  wire                           cand_tag,
  input  wire [btnck_pkg::SRC_W-1:0]    cand_source,
  input  wire                           start_new,
  input  wire                           emit_after,
  output logic                          out_strobe,
  output logic [btnck_pkg::SCORE_W-1:0] out_score,
  output logic                          out_tag,
  output logic [btnck_pkg::SRC_W-1:0]   out_source,
  output logic [btnck_pkg::IDX_W-1:0]   out_rank,
  output logic                          run_last
);

  // Capacity in use is bounded by the eight-entry store.
  localparam int Cap = (BEAM_WIDTH < 1) ? 1 :
                       ((BEAM_WIDTH > btnck_pkg::STORE_DEPTH) ? btnck_pkg::STORE_DEPTH
                                                              : BEAM_WIDTH);

  btnck_pkg::cmd_t cmd;
  btnck_pkg::sts_t sts;

  btnck_ctrl #(
    .Cap(Cap)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_new  (start_new),
    .emit_after (emit_after),
    .busy       (busy),
    .cmd        (cmd),
    .sts        (sts)
  );

  btnck_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cand_score  (cand_score),
    .cand_tag    (cand_tag),
    .cand_source (cand_source),
    .out_strobe  (out_strobe),
    .out_score   (out_score),
    .out_tag     (out_tag),
    .out_source  (out_source),
    .out_rank    (out_rank),
    .run_last    (run_last)
  );

  // A result is only ever read out while a transaction is in progress.
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    out_strobe |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // Every accepted transaction raises busy in the cycle after it is accepted.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Ranks of one emitted list come in consecutive cycles, counting up.
  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    (out_strobe && !run_last) |=> (out_strobe && out_rank == $past(out_rank) + 3'd1))
    else $error("emitted ranks are not consecutive");

  // The last entry of a list closes the run.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (out_strobe && run_last) |=> !out_strobe)
    else $error("result strobe after the last entry");

endmodule
`default_nettype wire
